>>> rtl/afs_pkg.sv
`timescale 1ns / 1ps

package afs_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int MAX_STEPS  = 1024;
  localparam int IDX_W      = $clog2(MAX_FRAMES);
  localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);
  localparam int DATA_W     = 32;
  localparam int DIV_CNT_W  = $clog2(DATA_W + 1);
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int CFG_AW     = 3;
  localparam int REG_IDX_W  = CFG_AW - 2;
  localparam int APB_DW     = 32;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT = REG_IDX_W'(0);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SET     = 2'd1,
    OP_STEP    = 2'd2,
    OP_ADVANCE = 2'd3
  } op_t;

  // command as it sits in the queue between front and back
  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  slot;
    logic              mark;
    logic [DATA_W-1:0] arg;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  frame_index;
    logic [DATA_W-1:0] time_consumed;
    logic              at_stop;
    logic              step_limit_hit;
  } result_t;

endpackage

>>> rtl/afs_if.sv
`timescale 1ns / 1ps

interface afs_in_if import afs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [IDX_W-1:0]  frame_slot;
  logic [DATA_W-1:0] delay_value;
  logic              stop_mark;
  logic [DATA_W-1:0] new_index;
  logic [DATA_W-1:0] time_delta;

  modport source (output valid, opcode, frame_slot, delay_value, stop_mark, new_index,
                  time_delta, input ready);
  modport sink   (input valid, opcode, frame_slot, delay_value, stop_mark, new_index,
                  time_delta, output ready);
endinterface

interface afs_out_if import afs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  frame_index;
  logic [DATA_W-1:0] time_consumed;
  logic              at_stop;
  logic              step_limit_hit;

  modport source (output valid, frame_index, time_consumed, at_stop, step_limit_hit,
                  input ready);
  modport sink   (input valid, frame_index, time_consumed, at_stop, step_limit_hit,
                  output ready);
endinterface

>>> rtl/afs_front.sv
`timescale 1ns / 1ps

module afs_front import afs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  afs_in_if.sink  in_ch,
  output logic    cmd_valid,
  output cmd_t    cmd,
  input  logic    cmd_pop
);

  cmd_t              q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              push;
  cmd_t              new_cmd;

  assign in_ch.ready = (count_r != (QPTR_W + 1)'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count_r != '0);
  assign cmd         = q_r[rd_ptr_r];

  // fold the operand that the opcode uses into one argument field
  always_comb begin
    new_cmd.op   = op_t'(in_ch.opcode);
    new_cmd.slot = in_ch.frame_slot;
    new_cmd.mark = in_ch.stop_mark;
    unique case (op_t'(in_ch.opcode))
      OP_LOAD:    new_cmd.arg = in_ch.delay_value;
      OP_SET:     new_cmd.arg = in_ch.new_index;
      OP_ADVANCE: new_cmd.arg = in_ch.time_delta;
      default:    new_cmd.arg = '0;
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = cmd_pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !cmd_pop) begin
      count_nxt = count_r + (QPTR_W + 1)'(1);
    end else if (!push && cmd_pop) begin
      count_nxt = count_r - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

>>> rtl/afs_mod.sv
`timescale 1ns / 1ps

// restoring remainder, one dividend bit per cycle
module afs_mod import afs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [CNT_W-1:0]  divisor,
  output logic              done,
  output logic [IDX_W-1:0]  rem
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [IDX_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     div_r, div_nxt;
  logic [CNT_W-1:0]     trial;
  logic [CNT_W-1:0]     trial_sub;

  assign done      = done_r;
  assign rem       = rem_r;
  assign trial     = {rem_r, quo_r[DATA_W-1]};
  assign trial_sub = trial - div_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DATA_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      rem_nxt = (trial >= div_r) ? trial_sub[IDX_W-1:0] : trial[IDX_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < div_r))
    else $error("remainder not below divisor");

endmodule

>>> rtl/afs_back.sv
`timescale 1ns / 1ps

module afs_back import afs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  input  logic [CNT_W-1:0] eff_count,
  afs_out_if.source        out_ch
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOD   = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_EVAL  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [DATA_W-1:0] left_r, left_nxt;
  logic [DATA_W-1:0] consumed_r, consumed_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic              capped_r, capped_nxt;
  logic              stepped_r, stepped_nxt;
  logic              at_stop_r, at_stop_nxt;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r, out_res_nxt;

  logic [DATA_W:0]   tbl_mem [MAX_FRAMES];
  logic [DATA_W:0]   rd_r;
  logic              mem_we;
  logic [DATA_W-1:0] rd_delay;
  logic              rd_stop;
  logic [CNT_W-1:0]  inc;
  logic [IDX_W-1:0]  idx_inc;

  logic              mod_start;
  logic              mod_done;
  logic [IDX_W-1:0]  mod_rem;

  afs_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (cmd.arg),
    .divisor  (eff_count),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // table: stop mark on top of the delay, read every cycle at the current index
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[cmd.slot] <= {cmd.mark, cmd.arg};
    end
    rd_r <= tbl_mem[idx_r];
  end

  assign rd_delay = rd_r[DATA_W-1:0];
  assign rd_stop  = rd_r[DATA_W];
  assign inc      = {1'b0, idx_r} + CNT_W'(1);
  assign idx_inc  = (inc >= eff_count) ? '0 : inc[IDX_W-1:0];

  assign out_ch.valid          = out_valid_r;
  assign out_ch.frame_index    = out_res_r.frame_index;
  assign out_ch.time_consumed  = out_res_r.time_consumed;
  assign out_ch.at_stop        = out_res_r.at_stop;
  assign out_ch.step_limit_hit = out_res_r.step_limit_hit;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    idx_nxt       = idx_r;
    left_nxt      = left_r;
    consumed_nxt  = consumed_r;
    steps_nxt     = steps_r;
    capped_nxt    = capped_r;
    stepped_nxt   = stepped_r;
    at_stop_nxt   = at_stop_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_res_nxt   = out_res_r;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mod_start     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop      = 1'b1;
          op_nxt       = cmd.op;
          left_nxt     = cmd.arg;
          consumed_nxt = '0;
          steps_nxt    = '0;
          capped_nxt   = 1'b0;
          stepped_nxt  = 1'b0;
          unique case (cmd.op)
            OP_LOAD: begin
              mem_we    = 1'b1;
              state_nxt = ST_FETCH;
            end
            OP_SET: begin
              mod_start = 1'b1;
              state_nxt = ST_MOD;
            end
            default: state_nxt = ST_FETCH;
          endcase
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          idx_nxt   = mod_rem;
          state_nxt = ST_FETCH;
        end
      end
      ST_FETCH: state_nxt = ST_EVAL;
      ST_EVAL: begin
        at_stop_nxt = rd_stop;
        state_nxt   = ST_DONE;
        unique case (op_r)
          OP_STEP: begin
            if (!rd_stop && !stepped_r) begin
              idx_nxt     = idx_inc;
              stepped_nxt = 1'b1;
              state_nxt   = ST_FETCH;
            end
          end
          OP_ADVANCE: begin
            priority if (rd_stop || (left_r < rd_delay)) begin
              state_nxt = ST_DONE;
            end else if (steps_r == STEP_W'(MAX_STEPS)) begin
              capped_nxt = 1'b1;
            end else begin
              consumed_nxt = consumed_r + rd_delay;
              left_nxt     = left_r - rd_delay;
              idx_nxt      = idx_inc;
              steps_nxt    = steps_r + STEP_W'(1);
              state_nxt    = ST_FETCH;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt              = 1'b1;
          out_res_nxt.frame_index    = idx_r;
          out_res_nxt.time_consumed  = consumed_r;
          out_res_nxt.at_stop        = at_stop_r;
          out_res_nxt.step_limit_hit = capped_r;
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
      capped_r    <= 1'b0;
      consumed_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      steps_r     <= steps_nxt;
      capped_r    <= capped_nxt;
      consumed_r  <= consumed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    left_r    <= left_nxt;
    stepped_r <= stepped_nxt;
    at_stop_r <= at_stop_nxt;
    out_res_r <= out_res_nxt;
  end

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> cmd_valid)
    else $error("queue popped while empty");

  a_steps_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    steps_r <= STEP_W'(MAX_STEPS))
    else $error("walk ran past the step cap");

  a_cap_only_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && capped_r) |-> (op_r == OP_ADVANCE && steps_r == STEP_W'(MAX_STEPS)))
    else $error("cap flagged without a full walk");

  a_no_time_off_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && op_r != OP_ADVANCE) |-> (consumed_r == '0))
    else $error("time consumed on a non-advance transaction");

endmodule

>>> rtl/animation_frame_stepper.sv
`timescale 1ns / 1ps

// flow: every transaction goes through FETCH and EVAL to DONE; set frame first runs the
//   remainder unit in MOD, and a moving step or advance loops back to FETCH once per frame
// throughput: one item in the back end at a time; the walk reads one table entry per
//   frame through the single read port, max 1024 frames
// reset: frame index 0, frame_count 1, queue and output empty; the table is not cleared
module animation_frame_stepper import afs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  afs_in_if.sink            in_ch,
  afs_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CNT_W-1:0]     frame_count_r, frame_count_nxt;
  logic [CNT_W-1:0]     eff_count;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;
  logic                 cmd_valid;
  cmd_t                 cmd;
  logic                 cmd_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_FRAME_COUNT);

  assign frame_count_nxt = cfg_wr ? pwdata[CNT_W-1:0] : frame_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= CNT_W'(1);
    end else begin
      frame_count_r <= frame_count_nxt;
    end
  end

  always_comb begin
    if (reg_idx == REG_FRAME_COUNT) begin
      prdata = {{(APB_DW - CNT_W){1'b0}}, frame_count_r};
    end else begin
      prdata = '0;
    end
  end

  // zero counts as one frame, anything above the table size as the full table
  always_comb begin
    priority if (frame_count_r == '0) begin
      eff_count = CNT_W'(1);
    end else if (frame_count_r > CNT_W'(MAX_FRAMES)) begin
      eff_count = CNT_W'(MAX_FRAMES);
    end else begin
      eff_count = frame_count_r;
    end
  end

  afs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  afs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .eff_count (eff_count),
    .out_ch    (out_ch)
  );

endmodule

>>> tb/animation_frame_stepper_tb.sv
`timescale 1ns / 1ps

module animation_frame_stepper_tb import afs_pkg::*; ();

  localparam int NUM_PHASES   = 12;
  localparam int PHASE_ITEMS  = 125;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  slot;
    logic [DATA_W-1:0] delay;
    logic              mark;
    logic [DATA_W-1:0] nidx;
    logic [DATA_W-1:0] delta;
  } frame_cmd_t;

  class frame_walk_checker;
    logic [DATA_W-1:0] delay_tab [MAX_FRAMES];
    logic              stop_tab [MAX_FRAMES];
    logic [IDX_W-1:0]  cur_frame = '0;
    logic [8:0]        count_reg = 9'd1;
    result_t           pending_frames [$];
    int                errors = 0;

    function void set_count(logic [APB_DW-1:0] v);
      count_reg = v[8:0];
    endfunction

    function int unsigned active_count();
      if (count_reg == 0) return 1;
      if (count_reg > MAX_FRAMES) return MAX_FRAMES;
      return count_reg;
    endfunction

    // stop frames hold, past the last frame wraps to 0
    function void step_one();
      int unsigned nxt;
      if (stop_tab[cur_frame]) return;
      nxt = cur_frame + 1;
      cur_frame = (nxt >= active_count()) ? '0 : IDX_W'(nxt);
    endfunction

    function void accept_cmd(frame_cmd_t c);
      result_t           r;
      logic [DATA_W-1:0] used;
      int unsigned       steps;
      bit                done;
      used  = '0;
      steps = 0;
      done  = 1'b0;
      r.step_limit_hit = 1'b0;
      case (c.op)
        OP_LOAD: begin
          delay_tab[c.slot] = c.delay;
          stop_tab[c.slot]  = c.mark;
        end
        OP_SET:  cur_frame = IDX_W'(c.nidx % active_count());
        OP_STEP: step_one();
        default: begin
          while (!done) begin
            if (stop_tab[cur_frame]) done = 1'b1;
            else if (c.delta - used < delay_tab[cur_frame]) done = 1'b1;
            else if (steps >= MAX_STEPS) begin
              r.step_limit_hit = 1'b1;
              done = 1'b1;
            end else begin
              used += delay_tab[cur_frame];
              step_one();
              steps++;
            end
          end
        end
      endcase
      r.frame_index   = cur_frame;
      r.time_consumed = used;
      r.at_stop       = stop_tab[cur_frame];
      pending_frames.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_frame(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] used, logic stop,
                     logic capped);
      result_t want;
      if (pending_frames.size() == 0) begin
        report_mismatch($sformatf("unexpected result idx %0d used %0h", idx, used));
        return;
      end
      want = pending_frames.pop_front();
      if (idx !== want.frame_index || used !== want.time_consumed ||
          stop !== want.at_stop || capped !== want.step_limit_hit)
        report_mismatch($sformatf(
          "got idx %0d used %0h stop %b cap %b, want idx %0d used %0h stop %b cap %b",
          idx, used, stop, capped, want.frame_index, want.time_consumed,
          want.at_stop, want.step_limit_hit));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  bit                quiet = 1'b0;

  logic [APB_DW-1:0] phase_counts [NUM_PHASES] = '{
    32'd1, 32'd2, 32'd256, 32'd0, 32'd511, 32'd3, 32'd255, 32'd8,
    32'hFFFF_FE06, 32'd16, 32'd0, 32'd0
  };

  frame_walk_checker walk = new();

  afs_in_if  in_if ();
  afs_out_if out_if ();

  animation_frame_stepper dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic frame_cmd_t build_cmd(op_t op, int unsigned slot,
                                           logic [DATA_W-1:0] val, logic mark);
    frame_cmd_t c;
    // fields the opcode does not use carry junk
    c.slot  = IDX_W'($urandom);
    c.delay = $urandom;
    c.mark  = 1'($urandom);
    c.nidx  = $urandom;
    c.delta = $urandom;
    c.op    = op;
    case (op)
      OP_LOAD: begin
        c.slot  = IDX_W'(slot);
        c.delay = val;
        c.mark  = mark;
      end
      OP_SET:     c.nidx  = val;
      OP_ADVANCE: c.delta = val;
      default: ;
    endcase
    return c;
  endfunction

  function automatic frame_cmd_t random_cmd(int unsigned n);
    int unsigned       pick;
    int unsigned       slot;
    logic [DATA_W-1:0] val;
    pick = $urandom_range(0, 99);
    slot = ($urandom_range(0, 4) == 0) ? $urandom_range(0, MAX_FRAMES - 1)
                                       : $urandom_range(0, n - 1);
    if (pick < 25) begin
      case ($urandom_range(0, 6))
        0:       val = '0;
        1, 2:    val = $urandom;
        default: val = $urandom_range(0, 15);
      endcase
      return build_cmd(OP_LOAD, slot, val, $urandom_range(0, 7) == 0);
    end
    if (pick < 40) begin
      val = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2 * n);
      return build_cmd(OP_SET, 0, val, 1'b0);
    end
    if (pick < 65) return build_cmd(OP_STEP, 0, '0, 1'b0);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: val = $urandom_range(0, 40);
      4, 5, 6:    val = $urandom_range(0, 5000);
      7, 8:       val = $urandom;
      default:    val = '1;
    endcase
    return build_cmd(OP_ADVANCE, 0, val, 1'b0);
  endfunction

  task automatic send_cmd(input frame_cmd_t c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.opcode      <= c.op;
    in_if.frame_slot  <= c.slot;
    in_if.delay_value <= c.delay;
    in_if.stop_mark   <= c.mark;
    in_if.new_index   <= c.nidx;
    in_if.time_delta  <= c.delta;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    walk.accept_cmd(c);
  endtask

  task automatic write_frame_count(input logic [APB_DW-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FRAME_COUNT, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    walk.set_count(v);
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (walk.pending_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      walk.check_frame(out_if.frame_index, out_if.time_consumed, out_if.at_stop,
                       out_if.step_limit_hit);
  end

  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    int unsigned       n;
    logic [APB_DW-1:0] cnt;
    in_if.valid       <= 1'b0;
    in_if.opcode      <= OP_LOAD;
    in_if.frame_slot  <= '0;
    in_if.delay_value <= '0;
    in_if.stop_mark   <= 1'b0;
    in_if.new_index   <= '0;
    in_if.time_delta  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // the table is not cleared by reset, so every entry is loaded first,
    // slot 0 before anything reads it
    write_frame_count(256);
    for (int s = 0; s < MAX_FRAMES; s++)
      send_cmd(build_cmd(OP_LOAD, s, $urandom_range(0, 12), $urandom_range(0, 11) == 0));

    send_cmd(build_cmd(OP_LOAD, 0, '1, 1'b1));
    send_cmd(build_cmd(OP_ADVANCE, 0, '1, 1'b0));
    send_cmd(build_cmd(OP_STEP, 0, '0, 1'b0));
    send_cmd(build_cmd(OP_SET, 0, '1, 1'b0));
    send_cmd(build_cmd(OP_LOAD, 255, '0, 1'b0));
    send_cmd(build_cmd(OP_STEP, 0, '0, 1'b0));
    send_cmd(build_cmd(OP_LOAD, 0, '1, 1'b0));
    send_cmd(build_cmd(OP_ADVANCE, 0, 32'hFFFF_FFFE, 1'b0));
    send_cmd(build_cmd(OP_LOAD, 1, '0, 1'b1));
    send_cmd(build_cmd(OP_ADVANCE, 0, '1, 1'b0));
    send_cmd(build_cmd(OP_SET, 0, '0, 1'b0));
    drain_results();
    // zero count acts as one; a zero delay with no stop runs into the step cap
    write_frame_count(0);
    send_cmd(build_cmd(OP_LOAD, 0, '0, 1'b0));
    send_cmd(build_cmd(OP_SET, 0, 32'd12345, 1'b0));
    send_cmd(build_cmd(OP_STEP, 0, '0, 1'b0));
    send_cmd(build_cmd(OP_ADVANCE, 0, '0, 1'b0));
    drain_results();
    write_frame_count(511);
    send_cmd(build_cmd(OP_SET, 0, '1, 1'b0));
    send_cmd(build_cmd(OP_STEP, 0, '0, 1'b0));
    send_cmd(build_cmd(OP_LOAD, 200, 32'd4, 1'b0));
    send_cmd(build_cmd(OP_SET, 0, 32'd200, 1'b0));
    drain_results();
    // index left beyond the new count until a step wraps it
    write_frame_count(3);
    send_cmd(build_cmd(OP_ADVANCE, 0, 32'd3, 1'b0));
    send_cmd(build_cmd(OP_STEP, 0, '0, 1'b0));
    send_cmd(build_cmd(OP_SET, 0, 32'd7, 1'b0));

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      cnt = (p >= 10) ? $urandom_range(1, MAX_FRAMES) : phase_counts[p];
      write_frame_count(cnt);
      if (p == NUM_PHASES - 1) quiet = 1'b1;
      n = walk.active_count();
      // short loops get a proper sequence so advances actually walk
      if (n <= 16)
        for (int s = 0; s < n; s++)
          send_cmd(build_cmd(OP_LOAD, s, $urandom_range(1, 9),
                             (s == n - 1) && ($urandom_range(0, 1) == 0)));
      for (int k = 0; k < PHASE_ITEMS; k++)
        send_cmd(random_cmd(n));
    end

    drain_results();
    repeat (60) @(posedge clk);
    if (walk.errors == 0) begin
      $display("animation_frame_stepper verification clean");
    end else begin
      $display("animation_frame_stepper verification failed");
    end
    $finish;
  end

  initial begin
    #500_000_000;
    $display("animation_frame_stepper verification failed");
    $finish;
  end

endmodule
